// ===== hw/rtl/tpcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tpcg_pkg
// Shared types and constants for the TV palette colour generator pipeline.
// ----------------------------------------------------------------------------
package tpcg_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int LVL_W  = 13;
  localparam int BASE_W = 12;
  localparam int MAG_W  = 18;

  localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [2:0] REG_CONTRAST   = 3'd1;
  localparam logic [2:0] REG_SATURATION = 3'd2;
  localparam logic [2:0] REG_NOISE      = 3'd3;
  localparam logic [2:0] REG_GHOST      = 3'd4;
  localparam logic [2:0] REG_SCANLINE   = 3'd5;
  localparam logic [2:0] REG_MODE       = 3'd6;

  localparam int MODE_VIBRANT  = 0;
  localparam int MODE_ARTIFACT = 1;
  localparam int MODE_INVERSE  = 2;
  localparam int MODE_FIXED    = 3;

  localparam int BASE_SCALE = 1000;
  localparam int HUE_OFFSET = 9;
  localparam int FIXED_HI   = 255;
  localparam int FIXED_LO   = 128;

  // floor(2^30 / 1000) and floor(2^24 / 255); quotients come out low by at most one
  localparam int DIV1000_K = 1073741;
  localparam int DIV255_K  = 65793;

  typedef logic signed [LVL_W-1:0]  lvl_t;
  typedef logic signed [BASE_W-1:0] base_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] contrast;
    logic [7:0] saturation;
    logic [5:0] noise;
    logic [6:0] ghost;
    logic [6:0] scanline;
    logic [3:0] mode;
  } cfg_t;

  typedef struct packed {
    logic [3:0] colour;
    logic [3:0] variant;
    base_t      grey;
    base_t      xr;
    base_t      xg;
    base_t      xb;
  } luma_t;

  typedef struct packed {
    logic [3:0] variant;
    lvl_t       lr;
    lvl_t       lg;
    lvl_t       lb;
  } chroma_t;

  function automatic logic [7:0] clamp8(input lvl_t v);
    logic [7:0] res;
    if (v[LVL_W-1]) begin
      res = 8'd0;
    end else if (v > lvl_t'(255)) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tpcg_cfg.sv =====
// ----------------------------------------------------------------------------
// tpcg_cfg
// APB register file holding the slider, offset and mode settings.
// ----------------------------------------------------------------------------
module tpcg_cfg import tpcg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [7:0] brightness_r;
  logic [7:0] contrast_r;
  logic [7:0] saturation_r;
  logic [5:0] noise_r;
  logic [6:0] ghost_r;
  logic [6:0] scanline_r;
  logic [3:0] mode_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 8'd128;
      contrast_r   <= 8'd128;
      saturation_r <= 8'd128;
      noise_r      <= 6'd0;
      ghost_r      <= 7'd0;
      scanline_r   <= 7'd0;
      mode_r       <= 4'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BRIGHTNESS: brightness_r <= pwdata[7:0];
        REG_CONTRAST:   contrast_r   <= pwdata[7:0];
        REG_SATURATION: saturation_r <= pwdata[7:0];
        REG_NOISE:      noise_r      <= pwdata[5:0];
        REG_GHOST:      ghost_r      <= pwdata[6:0];
        REG_SCANLINE:   scanline_r   <= pwdata[6:0];
        REG_MODE:       mode_r       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BRIGHTNESS: prdata = DATA_W'(brightness_r);
      REG_CONTRAST:   prdata = DATA_W'(contrast_r);
      REG_SATURATION: prdata = DATA_W'(saturation_r);
      REG_NOISE:      prdata = DATA_W'(noise_r);
      REG_GHOST:      prdata = DATA_W'(ghost_r);
      REG_SCANLINE:   prdata = DATA_W'(scanline_r);
      REG_MODE:       prdata = DATA_W'(mode_r);
      default:        prdata = '0;
    endcase
  end

  assign cfg = '{brightness: brightness_r, contrast: contrast_r, saturation: saturation_r,
                 noise: noise_r, ghost: ghost_r, scanline: scanline_r, mode: mode_r};

endmodule

// ===== hw/rtl/tpcg_luma.sv =====
// ----------------------------------------------------------------------------
// tpcg_luma
// Four-stage front end: colour decode, level ramp, divide by 1000 and
// per-channel chroma offsets around the grey level.
// ----------------------------------------------------------------------------
module tpcg_luma import tpcg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       up_valid,
  output logic       up_ready,
  input  logic [7:0] up_index,
  output logic       dn_valid,
  input  logic       dn_ready,
  output luma_t      dn_data
);

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  logic [3:0]        s1_colour_r, s2_colour_r, s3_colour_r;
  logic [3:0]        s1_variant_r, s2_variant_r, s3_variant_r;
  logic signed [9:0] s1_bl_r, s2_bl_r, s3_bl_r;
  logic [9:0]        s1_d_r, s2_d_r, s3_d_r;
  logic [15:0]       s1_diff_r;
  logic [19:0]       s2_prod_r, s3_prod_r;
  logic [9:0]        s3_q_r;
  luma_t             s4_data_r;

  assign s4_rdy   = !s4_vld_r || dn_ready;
  assign s3_rdy   = !s3_vld_r || s4_rdy;
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign up_ready = s1_rdy;
  assign dn_valid = s4_vld_r;
  assign dn_data  = s4_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= up_valid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
      if (s4_rdy) s4_vld_r <= s3_vld_r;
    end
  end

  // stage 1: colour code, black level and top-of-ramp distance
  logic [3:0]        colour_in;
  logic [7:0]        cl;
  logic signed [9:0] bl_in;
  logic [9:0]        d_in;
  logic [19:0]       dk;

  always_comb begin
    colour_in = cfg.mode[MODE_INVERSE] ? {up_index[7], ~up_index[6:4]} : up_index[7:4];
    cl        = ~cfg.contrast;
    bl_in     = $signed({2'b00, ~cfg.brightness}) - $signed({2'b00, cl});
    d_in      = colour_in[3] ? ({1'b0, cl, 1'b0} + {3'b000, cl[7:1]}) : {1'b0, cl, 1'b0};
    dk        = 20'(d_in) * 20'(BASE_SCALE);
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && up_valid) begin
      s1_colour_r  <= colour_in;
      s1_variant_r <= up_index[3:0];
      s1_bl_r      <= bl_in;
      s1_d_r       <= d_in;
      s1_diff_r    <= dk[19:4];
    end
  end

  // stage 2: scale ramp step by hue weight
  logic [4:0]  hue_k;
  logic [20:0] ramp;

  always_comb begin
    hue_k = 5'(s1_colour_r[2:0]) + 5'(HUE_OFFSET);
    ramp  = 21'(s1_diff_r) * 21'(hue_k);
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_vld_r) begin
      s2_colour_r  <= s1_colour_r;
      s2_variant_r <= s1_variant_r;
      s2_bl_r      <= s1_bl_r;
      s2_d_r       <= s1_d_r;
      s2_prod_r    <= ramp[19:0];
    end
  end

  // stage 3: reciprocal estimate of ramp / 1000
  logic [40:0] recip;

  assign recip = 41'(s2_prod_r) * 41'(DIV1000_K);

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_vld_r) begin
      s3_colour_r  <= s2_colour_r;
      s3_variant_r <= s2_variant_r;
      s3_bl_r      <= s2_bl_r;
      s3_d_r       <= s2_d_r;
      s3_prod_r    <= s2_prod_r;
      s3_q_r       <= recip[39:30];
    end
  end

  // stage 4: correct quotient, form grey and channel offsets
  logic [20:0] rem;
  logic [9:0]  basec_u;
  base_t       bl_x, basec, grey, dx, nb, xr, xg, xb;

  always_comb begin
    rem     = 21'(s3_prod_r) - 21'(s3_q_r) * 21'(BASE_SCALE);
    basec_u = (rem >= 21'(BASE_SCALE)) ? s3_q_r + 10'd1 : s3_q_r;
    bl_x    = {{(BASE_W-10){s3_bl_r[9]}}, s3_bl_r};
    basec   = (s3_colour_r[2:0] == 3'd0) ? bl_x : $signed({2'b00, basec_u});
    grey    = bl_x + basec;
    dx      = $signed({2'b00, s3_d_r}) - basec;
    nb      = -basec;
    if (cfg.mode[MODE_VIBRANT]) begin
      xr = s3_colour_r[1] ? dx : nb;
      xg = s3_colour_r[2] ? dx : nb;
      xb = s3_colour_r[0] ? dx : nb;
    end else begin
      xr = s3_colour_r[1] ? '0 : nb;
      xg = s3_colour_r[2] ? '0 : nb;
      xb = s3_colour_r[0] ? '0 : nb;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_vld_r) begin
      s4_data_r <= '{colour: s3_colour_r, variant: s3_variant_r, grey: grey,
                     xr: xr, xg: xg, xb: xb};
    end
  end

endmodule

// ===== hw/rtl/tpcg_chroma.sv =====
// ----------------------------------------------------------------------------
// tpcg_chroma
// Three-stage saturation scaler: offset times saturation, divide by 255
// toward zero, add back the grey level; fixed chroma overrides the result.
// ----------------------------------------------------------------------------
module tpcg_chroma import tpcg_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    up_valid,
  output logic    up_ready,
  input  luma_t   up_data,
  output logic    dn_valid,
  input  logic    dn_ready,
  output chroma_t dn_data
);

  logic s5_vld_r, s6_vld_r, s7_vld_r;
  logic s5_rdy, s6_rdy, s7_rdy;

  logic [3:0]       s5_colour_r, s6_colour_r;
  logic [3:0]       s5_variant_r, s6_variant_r;
  base_t            s5_grey_r, s6_grey_r;
  logic [2:0]       s5_neg_r, s6_neg_r;
  logic [MAG_W-1:0] s5_mag_r [3];
  logic [MAG_W-1:0] s6_mag_r [3];
  logic [9:0]       s6_q_r [3];
  chroma_t          s7_data_r;

  assign s7_rdy   = !s7_vld_r || dn_ready;
  assign s6_rdy   = !s6_vld_r || s7_rdy;
  assign s5_rdy   = !s5_vld_r || s6_rdy;
  assign up_ready = s5_rdy;
  assign dn_valid = s7_vld_r;
  assign dn_data  = s7_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else begin
      if (s5_rdy) s5_vld_r <= up_valid;
      if (s6_rdy) s6_vld_r <= s5_vld_r;
      if (s7_rdy) s7_vld_r <= s6_vld_r;
    end
  end

  // stage 5: magnitude times saturation
  base_t            x_in [3];
  logic [BASE_W-1:0] ax [3];
  logic [MAG_W-1:0]  mag [3];
  logic [7:0]        sat;

  always_comb begin
    sat     = ~cfg.saturation;
    x_in[0] = up_data.xr;
    x_in[1] = up_data.xg;
    x_in[2] = up_data.xb;
    for (int i = 0; i < 3; i++) begin
      ax[i]  = x_in[i][BASE_W-1] ? BASE_W'(-x_in[i]) : BASE_W'(x_in[i]);
      mag[i] = MAG_W'(ax[i][10:0]) * MAG_W'(sat);
    end
  end

  always_ff @(posedge clk) begin
    if (s5_rdy && up_valid) begin
      s5_colour_r  <= up_data.colour;
      s5_variant_r <= up_data.variant;
      s5_grey_r    <= up_data.grey;
      for (int i = 0; i < 3; i++) begin
        s5_neg_r[i] <= x_in[i][BASE_W-1];
        s5_mag_r[i] <= mag[i];
      end
    end
  end

  // stage 6: reciprocal estimate of magnitude / 255
  logic [35:0] recip [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      recip[i] = 36'(s5_mag_r[i]) * 36'(DIV255_K);
    end
  end

  always_ff @(posedge clk) begin
    if (s6_rdy && s5_vld_r) begin
      s6_colour_r  <= s5_colour_r;
      s6_variant_r <= s5_variant_r;
      s6_grey_r    <= s5_grey_r;
      s6_neg_r     <= s5_neg_r;
      for (int i = 0; i < 3; i++) begin
        s6_mag_r[i] <= s5_mag_r[i];
        s6_q_r[i]   <= recip[i][33:24];
      end
    end
  end

  // stage 7: correct quotient, restore sign, add grey
  logic [MAG_W-1:0] rem [3];
  logic [9:0]       q [3];
  lvl_t             lvl [3];
  lvl_t             grey_x;
  lvl_t             fixed_on;
  logic [2:0]       fixed_bit;

  always_comb begin
    grey_x    = {{(LVL_W-BASE_W){s6_grey_r[BASE_W-1]}}, s6_grey_r};
    fixed_on  = s6_colour_r[3] ? lvl_t'(FIXED_HI) : lvl_t'(FIXED_LO);
    fixed_bit = {s6_colour_r[0], s6_colour_r[2], s6_colour_r[1]};
    for (int i = 0; i < 3; i++) begin
      rem[i] = s6_mag_r[i] - MAG_W'(s6_q_r[i]) * MAG_W'(255);
      q[i]   = (rem[i] >= MAG_W'(255)) ? s6_q_r[i] + 10'd1 : s6_q_r[i];
      if (cfg.mode[MODE_FIXED]) begin
        lvl[i] = fixed_bit[i] ? fixed_on : '0;
      end else if (s6_neg_r[i]) begin
        lvl[i] = grey_x - $signed({3'b000, q[i]});
      end else begin
        lvl[i] = grey_x + $signed({3'b000, q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s7_rdy && s6_vld_r) begin
      s7_data_r <= '{variant: s6_variant_r, lr: lvl[0], lg: lvl[1], lb: lvl[2]};
    end
  end

endmodule

// ===== hw/rtl/tpcg_out.sv =====
// ----------------------------------------------------------------------------
// tpcg_out
// Output stage: shade variant offsets, artifact-mode scanline offset and clamps
// into the result register, with RGB565 packing taken from that register.
// ----------------------------------------------------------------------------
module tpcg_out import tpcg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        up_valid,
  output logic        up_ready,
  input  chroma_t     up_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_level,
  output logic [7:0]  out_green_level,
  output logic [7:0]  out_blue_level,
  output logic [15:0] out_packed_rgb565
);

  logic       out_vld_r;
  logic       rdy;
  logic [7:0] red_r, green_r, blue_r;

  assign rdy      = !out_vld_r || !out_stall;
  assign up_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (rdy) begin
      out_vld_r <= up_valid;
    end
  end

  function automatic logic signed [7:0] div3_trunc(input logic signed [7:0] v);
    logic [7:0]  m;
    logic [15:0] p;
    logic [7:0]  q;
    m = v[7] ? 8'(-v) : 8'(v);
    p = 16'(m) * 16'd171;
    q = {1'b0, p[15:9]};
    return v[7] ? $signed(-q) : $signed(q);
  endfunction

  logic signed [7:0] n_off, g_off, s_off, g3_off;
  logic signed [8:0] add;
  lvl_t              lvl [3];
  logic [7:0]        c1 [3];
  logic [7:0]        c2 [3];

  always_comb begin
    n_off  = -$signed({{2{cfg.noise[5]}}, cfg.noise});
    g_off  = -$signed({cfg.ghost[6], cfg.ghost});
    s_off  = -$signed({cfg.scanline[6], cfg.scanline});
    g3_off = div3_trunc(g_off);
    case (up_data.variant[1:0])
      2'd0:    add = '0;
      2'd1:    add = $signed({n_off[7], n_off});
      2'd2:    add = $signed({g_off[7], g_off});
      2'd3:    add = $signed({n_off[7], n_off}) + $signed({g_off[7], g_off});
      default: add = '0;
    endcase
    if (up_data.variant[2] && (up_data.variant[1:0] != 2'd3)) begin
      add = add + $signed({g3_off[7], g3_off});
    end
    lvl[0] = up_data.lr;
    lvl[1] = up_data.lg;
    lvl[2] = up_data.lb;
    for (int i = 0; i < 3; i++) begin
      c1[i] = clamp8(lvl[i] + {{(LVL_W-9){add[8]}}, add});
      if (up_data.variant[3] && cfg.mode[MODE_ARTIFACT]) begin
        c2[i] = clamp8($signed({{(LVL_W-8){1'b0}}, c1[i]}) + {{(LVL_W-8){s_off[7]}}, s_off});
      end else begin
        c2[i] = c1[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && up_valid) begin
      red_r   <= c2[0];
      green_r <= c2[1];
      blue_r  <= c2[2];
    end
  end

  assign out_valid         = out_vld_r;
  assign out_red_level     = red_r;
  assign out_green_level   = green_r;
  assign out_blue_level    = blue_r;
  assign out_packed_rgb565 = {red_r[7:3], green_r[7:2], blue_r[7:3]};

endmodule

// ===== hw/rtl/tv_palette_colour_generator.sv =====
// ----------------------------------------------------------------------------
// tv_palette_colour_generator
// Palette index to clamped RGB888 and RGB565 colour, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one palette index per clock unless stalled and passes it through
// eight register stages, the last holding the colour. Every stage holds its
// own valid bit, so a stall on the output backs up stage by stage and empty
// stages still take new beats. The input is stalled while reset is asserted.
// The depth is set by the two constant divisions (by 1000 and by 255), each
// done as a reciprocal multiply followed by a one-step correction. Settings
// are taken through the APB port and apply to beats accepted after the write;
// write them only while no beat is in flight.
module tv_palette_colour_generator import tpcg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_palette_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_red_level,
  output logic [7:0]        out_green_level,
  output logic [7:0]        out_blue_level,
  output logic [15:0]       out_packed_rgb565
);

  cfg_t    cfg;
  logic    in_ready;
  logic    luma_valid, luma_ready;
  luma_t   luma_data;
  logic    chroma_valid, chroma_ready;
  chroma_t chroma_data;

  assign in_stall = !in_ready || !rst_n;

  tpcg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpcg_luma u_luma (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_index (in_palette_index),
    .dn_valid (luma_valid),
    .dn_ready (luma_ready),
    .dn_data  (luma_data)
  );

  tpcg_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (luma_valid),
    .up_ready (luma_ready),
    .up_data  (luma_data),
    .dn_valid (chroma_valid),
    .dn_ready (chroma_ready),
    .dn_data  (chroma_data)
  );

  tpcg_out u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .up_valid          (chroma_valid),
    .up_ready          (chroma_ready),
    .up_data           (chroma_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red_level     (out_red_level),
    .out_green_level   (out_green_level),
    .out_blue_level    (out_blue_level),
    .out_packed_rgb565 (out_packed_rgb565)
  );

endmodule

// ===== tb/tv_palette_colour_generator_tb.sv =====
// ----------------------------------------------------------------------------
// tv_palette_colour_generator_tb
// Self-checking bench for the palette index to RGB888/RGB565 colour pipeline.
// ----------------------------------------------------------------------------
// Runs sixteen settings phases: reset values first, then slider and offset
// extremes, in-range and full-width random settings, covering every mode
// combination. Settings go in over APB only while the pipeline is empty.
// Indexes are offered back to back or in bursts with random gaps, and the result side stalls
// randomly, on a fixed pattern, or not at all; one phase holds the output for
// a long stretch so the pipe backs up. Each beat is predicted on acceptance
// and every result beat is checked in order, field by field.
// ----------------------------------------------------------------------------
module tv_palette_colour_generator_tb;
  import tpcg_pkg::*;

  localparam logic [2:0] REG_UNUSED   = 3'd7;
  localparam int         PHASES       = 16;
  localparam int         PHASE_ITEMS  = 125;
  localparam int         PIPE_DRAIN   = 12;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         IDLE_LIMIT   = 2000;
  localparam int         REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] rgb565;
  } colour_t;

  typedef struct packed {
    logic [7:0] index;
    colour_t    colour;
  } lookup_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_palette_index = 8'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_red_level;
  logic [7:0]        out_green_level;
  logic [7:0]        out_blue_level;
  logic [15:0]       out_packed_rgb565;

  cfg_t        palette_cfg;
  logic [7:0]  palette_q[$];
  lookup_t     colour_q[$];
  logic        in_took = 1'b0;
  int          mismatches = 0;
  int          idle_cycles = 0;

  logic        send_bursty = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;

  int          stall_style = 0;
  logic        hold_armed = 1'b0;
  logic        hold_served = 1'b0;
  int          hold_left = 0;
  int          stall_tick = 0;

  tv_palette_colour_generator u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_palette_index  (in_palette_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_red_level     (out_red_level),
    .out_green_level   (out_green_level),
    .out_blue_level    (out_blue_level),
    .out_packed_rgb565 (out_packed_rgb565)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int limit_byte(input int v);
    return (v > 255) ? 255 : ((v < 0) ? 0 : v);
  endfunction

  function automatic colour_t predict_colour(input logic [7:0] ix);
    int code, hue, on, bl, cl, sat, hi, lo, top, diff, basec;
    int cr, cg, cb, grey, base_r, base_g, base_b;
    int nz, gh, sc, add, r, g, b;
    colour_t res;
    code = int'(ix[7:4]);
    hue = code;
    if (palette_cfg.mode[MODE_INVERSE]) hue = (code & 8) + (7 - (code & 7));
    if (palette_cfg.mode[MODE_FIXED]) begin
      on = (hue & 8) ? 255 : 128;
      base_r = (hue & 2) ? on : 0;
      base_g = (hue & 4) ? on : 0;
      base_b = (hue & 1) ? on : 0;
    end else begin
      bl = 255 - int'(palette_cfg.brightness);
      cl = 255 - int'(palette_cfg.contrast);
      sat = 255 - int'(palette_cfg.saturation);
      bl = bl - cl;
      hi = bl + cl / 2 + 2 * cl;
      lo = bl + cl + cl;
      top = (hue > 7) ? hi : lo;
      diff = (1000 * (top - bl)) / 16;
      basec = (diff * ((hue & 7) + 9)) / 1000;
      if (hue == 0 || hue == 8) basec = bl;
      if (palette_cfg.mode[MODE_VIBRANT]) begin
        cb = (hue & 1) ? top : bl;
        cg = (hue & 4) ? top : bl;
        cr = (hue & 2) ? top : bl;
      end else begin
        cb = bl + ((hue & 1) ? basec : 0);
        cg = bl + ((hue & 4) ? basec : 0);
        cr = bl + ((hue & 2) ? basec : 0);
      end
      grey = bl + basec;
      base_r = ((cr - grey) * sat) / 255 + grey;
      base_g = ((cg - grey) * sat) / 255 + grey;
      base_b = ((cb - grey) * sat) / 255 + grey;
    end
    nz = int'($signed(palette_cfg.noise));
    gh = int'($signed(palette_cfg.ghost));
    sc = int'($signed(palette_cfg.scanline));
    nz = -nz;
    gh = -gh;
    sc = -sc;
    case (ix[1:0])
      2'd1: add = nz;
      2'd2: add = gh;
      2'd3: add = nz + gh;
      default: add = 0;
    endcase
    if (ix[2] && ix[1:0] != 2'd3) add = add + gh / 3;
    r = limit_byte(base_r + add);
    g = limit_byte(base_g + add);
    b = limit_byte(base_b + add);
    if (ix[3] && palette_cfg.mode[MODE_ARTIFACT]) begin
      r = limit_byte(r + sc);
      g = limit_byte(g + sc);
      b = limit_byte(b + sc);
    end
    res.red = r[7:0];
    res.green = g[7:0];
    res.blue = b[7:0];
    res.rgb565 = {res.red[7:3], res.green[7:2], res.blue[7:3]};
    return res;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BRIGHTNESS: palette_cfg.brightness = value[7:0];
      REG_CONTRAST:   palette_cfg.contrast = value[7:0];
      REG_SATURATION: palette_cfg.saturation = value[7:0];
      REG_NOISE:      palette_cfg.noise = value[5:0];
      REG_GHOST:      palette_cfg.ghost = value[6:0];
      REG_SCANLINE:   palette_cfg.scanline = value[6:0];
      REG_MODE:       palette_cfg.mode = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drive: advance on acceptance, hold a stalled beat
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (palette_q.size() > 0) begin
        in_valid <= 1'b1;
        in_palette_index <= palette_q.pop_front();
        if (send_bursty) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left = $urandom_range(1, 8);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side stall pattern
  always @(negedge clk) begin
    stall_tick++;
    if (hold_armed && !hold_served) begin
      hold_served = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ((stall_tick % 7) < 3);
      endcase
    end
  end

  // predict on input beat, check on result beat, watch for a hang
  always @(posedge clk) begin
    lookup_t want;
    logic    busy;
    busy = 1'b0;
    in_took <= in_valid && !in_stall;
    if (in_valid && !in_stall) begin
      busy = 1'b1;
      want.index = in_palette_index;
      want.colour = predict_colour(in_palette_index);
      colour_q = {colour_q, want};
    end
    if (out_valid && !out_stall) begin
      busy = 1'b1;
      if (colour_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result beat: r=%h g=%h b=%h rgb565=%h", out_red_level,
                   out_green_level, out_blue_level, out_packed_rgb565);
        mismatches++;
      end else begin
        want = colour_q.pop_front();
        if (out_red_level !== want.colour.red || out_green_level !== want.colour.green ||
            out_blue_level !== want.colour.blue ||
            out_packed_rgb565 !== want.colour.rgb565) begin
          if (mismatches < REPORT_LIMIT)
            $display("index %h: expected r=%h g=%h b=%h rgb565=%h, got r=%h g=%h b=%h rgb565=%h",
                     want.index, want.colour.red, want.colour.green, want.colour.blue,
                     want.colour.rgb565, out_red_level, out_green_level, out_blue_level,
                     out_packed_rgb565);
          mismatches++;
        end
      end
    end
    if (psel && penable) busy = 1'b1;
    idle_cycles = busy ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL tv_palette_colour_generator");
      $finish;
    end
  end

  initial begin
    logic [7:0] directed[] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h01, 8'h02,
                               8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h0B, 8'h0C,
                               8'h0E, 8'h8F, 8'h55, 8'hAA, 8'h37, 8'hC8};
    logic [7:0] bri, con, sat;
    logic [5:0] nz;
    logic [6:0] gh, sc;
    palette_cfg.brightness = 8'd128;
    palette_cfg.contrast = 8'd128;
    palette_cfg.saturation = 8'd128;
    palette_cfg.noise = '0;
    palette_cfg.ghost = '0;
    palette_cfg.scanline = '0;
    palette_cfg.mode = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        case (p % 4)
          1: begin
            bri = 8'd0; con = 8'd0; sat = 8'd0;
            nz = 6'h20; gh = 7'h40; sc = 7'h40;
          end
          2: begin
            bri = 8'hFF; con = 8'hFF; sat = 8'hFF;
            nz = 6'h1F; gh = 7'h3F; sc = 7'h3F;
          end
          3: begin
            bri = 8'($urandom_range(0, 255)); con = 8'($urandom_range(0, 255));
            sat = 8'($urandom_range(0, 255));
            nz = 6'(int'($urandom_range(0, 40)) - 20);
            gh = 7'(int'($urandom_range(0, 80)) - 40);
            sc = 7'(int'($urandom_range(0, 80)) - 40);
          end
          default: begin
            bri = 8'($urandom); con = 8'($urandom); sat = 8'($urandom);
            nz = 6'($urandom); gh = 7'($urandom); sc = 7'($urandom);
          end
        endcase
        cfg_write(REG_BRIGHTNESS, {8'd0, bri});
        cfg_write(REG_CONTRAST, {8'd0, con});
        cfg_write(REG_SATURATION, {8'd0, sat});
        cfg_write(REG_NOISE, {10'd0, nz});
        cfg_write(REG_GHOST, {9'd0, gh});
        cfg_write(REG_SCANLINE, {9'd0, sc});
        cfg_write(REG_MODE, 16'(p));
        if (p % 5 == 2) cfg_write(REG_UNUSED, 16'($urandom));
      end
      send_bursty = (p % 4 != 3);
      stall_style = (p == 3) ? 0 : p % 4;
      if (p == 0) begin
        foreach (directed[i]) palette_q = {palette_q, directed[i]};
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        palette_q = {palette_q, 8'($urandom_range(0, 255))};
      end
      if (p == 3) hold_armed = 1'b1;
      while (palette_q.size() > 0 || in_valid || colour_q.size() > 0) @(posedge clk);
      repeat (PIPE_DRAIN) @(posedge clk);
    end

    if (mismatches == 0 && colour_q.size() == 0) begin
      $display("PASS tv_palette_colour_generator");
    end else begin
      $display("FAIL tv_palette_colour_generator");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tpcg_pkg.sv
hw/rtl/tpcg_cfg.sv
hw/rtl/tpcg_luma.sv
hw/rtl/tpcg_chroma.sv
hw/rtl/tpcg_out.sv
hw/rtl/tv_palette_colour_generator.sv
tb/tv_palette_colour_generator_tb.sv
